[hw/rtl/pos_pkg.sv]
package pos_pkg;

    // coordinate and register widths
    localparam int COORD_W     = 16;
    localparam int WIDTH_W     = 16;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 16'd16;

    // derived datapath widths
    localparam int DIFF_W  = COORD_W + 1;
    localparam int TAN_W   = COORD_W + 2;
    localparam int MAG_W   = COORD_W + 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int LEN_W   = SQ_W + 1;
    localparam int PROD_W  = WIDTH_W + MAG_W;
    localparam int A2_W    = 2 * PROD_W;
    localparam int ACC_W   = A2_W + 6;
    localparam int Q_W     = 16;
    localparam int STEP_W  = $clog2(Q_W);
    localparam int SUM_W   = COORD_W + 2;

    // scaling of the incremental square terms at the first search step
    localparam int INIT_U_SHIFT = Q_W + 1;
    localparam int INIT_V_SHIFT = 2 * Q_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_LOAD2,
        S_ABS,
        S_SQ,
        S_LEN_X,
        S_INIT_X,
        S_ITER_X,
        S_SAVE,
        S_LEN_Y,
        S_INIT_Y,
        S_ITER_Y,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        SEEN_NONE,
        SEEN_ONE,
        SEEN_PRIOR
    } t_seen;

    typedef enum logic [1:0] {
        WS_HELD_FIRST,
        WS_HELD_MID,
        WS_LAST,
        WS_SINGLE
    } t_work_sel;

    typedef enum logic [2:0] {
        PH_NONE,
        PH_ABS,
        PH_SQ,
        PH_LEN,
        PH_INIT,
        PH_ITER,
        PH_SAVE,
        PH_OUT
    } t_phase;

    typedef struct packed {
        logic      latch_in;
        logic      upd_path;
        logic      ld_work;
        t_work_sel sel;
        t_phase    phase;
    } t_dp_cmd;

    typedef struct packed {
        logic iter_last;
        logic out_free;
    } t_dp_status;

endpackage

[hw/rtl/pos_in_if.sv]
interface pos_in_if import pos_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      path_end;

    modport source (output valid, output point_x, output point_y, output path_end,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input path_end,
                  output ready);
endinterface

[hw/rtl/pos_out_if.sv]
interface pos_out_if import pos_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] left_y;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] right_y;
    logic                      degenerate;
    logic                      final_result;

    modport source (output valid, output left_x, output left_y, output right_x,
                    output right_y, output degenerate, output final_result,
                    input ready);
    modport sink (input valid, input left_x, input left_y, input right_x,
                  input right_y, input degenerate, input final_result,
                  output ready);
endinterface

[hw/rtl/pos_cfg_if.sv]
interface pos_cfg_if import pos_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [WIDTH_W-1:0] stroke_width;

    modport source (output valid, output stroke_width, input ready);
    modport sink (input valid, input stroke_width, output ready);
endinterface

[hw/rtl/pos_ctrl.sv]
module pos_ctrl import pos_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_path_end,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    t_seen  r_seen, n_seen;
    logic   r_end, n_end;
    logic   r_more, n_more;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seen  <= SEEN_NONE;
            r_end   <= 1'b0;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;
            r_end   <= n_end;
            r_more  <= n_more;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_seen     = r_seen;
        n_end      = r_end;
        n_more     = r_more;
        o_in_ready = 1'b0;
        o_cmd      = '{latch_in: 1'b0, upd_path: 1'b0, ld_work: 1'b0,
                       sel: WS_HELD_FIRST, phase: PH_NONE};
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_end          = i_path_end;
                    n_state        = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_seen == SEEN_NONE) begin
                    if (r_end) begin
                        // lone point: one result with a zero normal
                        o_cmd.ld_work = 1'b1;
                        o_cmd.sel     = WS_SINGLE;
                        n_more        = 1'b0;
                        n_state       = S_ABS;
                    end else begin
                        o_cmd.upd_path = 1'b1;
                        n_seen         = SEEN_ONE;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.ld_work = 1'b1;
                    o_cmd.sel     = (r_seen == SEEN_ONE) ? WS_HELD_FIRST : WS_HELD_MID;
                    if (r_end) begin
                        // held point stays put so the last point can reuse its difference
                        n_more = 1'b1;
                        n_seen = SEEN_NONE;
                    end else begin
                        o_cmd.upd_path = 1'b1;
                        n_more         = 1'b0;
                        n_seen         = SEEN_PRIOR;
                    end
                    n_state = S_ABS;
                end
            end
            S_LOAD2: begin
                o_cmd.ld_work = 1'b1;
                o_cmd.sel     = WS_LAST;
                n_more        = 1'b0;
                n_state       = S_ABS;
            end
            S_ABS: begin
                o_cmd.phase = PH_ABS;
                n_state     = S_SQ;
            end
            S_SQ: begin
                o_cmd.phase = PH_SQ;
                n_state     = S_LEN_X;
            end
            S_LEN_X: begin
                o_cmd.phase = PH_LEN;
                n_state     = S_INIT_X;
            end
            S_INIT_X: begin
                o_cmd.phase = PH_INIT;
                n_state     = S_ITER_X;
            end
            S_ITER_X: begin
                o_cmd.phase = PH_ITER;
                if (i_status.iter_last) begin
                    n_state = S_SAVE;
                end
            end
            S_SAVE: begin
                o_cmd.phase = PH_SAVE;
                n_state     = S_LEN_Y;
            end
            S_LEN_Y: begin
                o_cmd.phase = PH_LEN;
                n_state     = S_INIT_Y;
            end
            S_INIT_Y: begin
                o_cmd.phase = PH_INIT;
                n_state     = S_ITER_Y;
            end
            S_ITER_Y: begin
                o_cmd.phase = PH_ITER;
                if (i_status.iter_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.phase = PH_OUT;
                    n_state     = r_more ? S_LOAD2 : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/pos_dpath.sv]
module pos_dpath import pos_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_status                o_status,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic                      i_cfg_valid,
    input  logic [WIDTH_W-1:0]        i_cfg_width,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic signed [COORD_W-1:0] o_left_x,
    output logic signed [COORD_W-1:0] o_left_y,
    output logic signed [COORD_W-1:0] o_right_x,
    output logic signed [COORD_W-1:0] o_right_y,
    output logic                      o_degenerate,
    output logic                      o_final
);

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SUM_W-1:0] v
    );
        logic [SUM_W-COORD_W:0] top;
        top = v[SUM_W-1:COORD_W-1];
        if (top == '0 || top == '1) begin
            sat_coord = v[COORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    logic [WIDTH_W-1:0]        r_width;
    logic signed [COORD_W-1:0] r_in_x, r_in_y;
    logic signed [COORD_W-1:0] r_held_x, r_held_y;
    logic signed [DIFF_W-1:0]  r_prior_dx, r_prior_dy;
    logic signed [COORD_W-1:0] r_cx, r_cy;
    logic signed [TAN_W-1:0]   r_tx, r_ty;
    logic                      r_last;
    logic [MAG_W-1:0]          r_ax, r_ay;
    logic                      r_deg;
    logic [SQ_W-1:0]           r_sqx, r_sqy;
    logic [PROD_W-1:0]         r_prod;
    logic [LEN_W-1:0]          r_len2;
    logic [A2_W-1:0]           r_a2;
    logic signed [ACC_W-1:0]   r_rem, r_u, r_v;
    logic [Q_W-1:0]            r_q, r_mx;
    logic [STEP_W-1:0]         r_step;

    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_out_lx, r_out_ly, r_out_rx, r_out_ry;
    logic                      r_out_deg, r_out_final;

    logic signed [DIFF_W-1:0]  w_dx, w_dy;
    logic signed [TAN_W-1:0]   w_tx, w_ty;
    logic signed [COORD_W-1:0] w_cx, w_cy;
    logic signed [TAN_W-1:0]   w_abs_x, w_abs_y;
    logic signed [ACC_W-1:0]   w_len_acc, w_cand, w_u_acc;
    logic                      w_take;
    logic signed [SUM_W-1:0]   w_mag_x, w_mag_y, w_nx, w_ny, w_cx_ext, w_cy_ext;

    assign w_dx = DIFF_W'(r_in_x) - DIFF_W'(r_held_x);
    assign w_dy = DIFF_W'(r_in_y) - DIFF_W'(r_held_y);

    always_comb begin
        case (i_cmd.sel)
            WS_HELD_FIRST: begin
                w_cx = r_held_x;
                w_cy = r_held_y;
                w_tx = {w_dx, 1'b0};
                w_ty = {w_dy, 1'b0};
            end
            WS_HELD_MID: begin
                w_cx = r_held_x;
                w_cy = r_held_y;
                w_tx = TAN_W'(r_prior_dx) + TAN_W'(w_dx);
                w_ty = TAN_W'(r_prior_dy) + TAN_W'(w_dy);
            end
            WS_LAST: begin
                w_cx = r_in_x;
                w_cy = r_in_y;
                w_tx = {w_dx, 1'b0};
                w_ty = {w_dy, 1'b0};
            end
            default: begin
                w_cx = r_in_x;
                w_cy = r_in_y;
                w_tx = '0;
                w_ty = '0;
            end
        endcase
    end

    assign w_abs_x = r_tx[TAN_W-1] ? -r_tx : r_tx;
    assign w_abs_y = r_ty[TAN_W-1] ? -r_ty : r_ty;

    // rounded search: largest q with (2q-1)^2 * len2 <= (w*c)^2, one bit a step;
    // rem = (w*c)^2 - (2q-1)^2 * len2, u and v carry the scaled cross and square terms
    assign w_len_acc = $signed(ACC_W'(r_len2));
    assign w_cand    = r_rem - r_u - r_v;
    assign w_take    = !w_cand[ACC_W-1];
    assign w_u_acc   = w_take ? (r_u + (r_v <<< 1)) : r_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_cfg_valid) begin
            r_width <= i_cfg_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in_x <= i_point_x;
            r_in_y <= i_point_y;
        end
        if (i_cmd.upd_path) begin
            r_held_x   <= r_in_x;
            r_held_y   <= r_in_y;
            r_prior_dx <= w_dx;
            r_prior_dy <= w_dy;
        end
        if (i_cmd.ld_work) begin
            r_cx   <= w_cx;
            r_cy   <= w_cy;
            r_tx   <= w_tx;
            r_ty   <= w_ty;
            r_last <= (i_cmd.sel == WS_LAST) || (i_cmd.sel == WS_SINGLE);
        end
        case (i_cmd.phase)
            PH_ABS: begin
                r_ax  <= w_abs_x[MAG_W-1:0];
                r_ay  <= w_abs_y[MAG_W-1:0];
                r_deg <= (r_tx == '0) && (r_ty == '0);
            end
            PH_SQ: begin
                r_sqx  <= SQ_W'(r_ax) * SQ_W'(r_ax);
                r_sqy  <= SQ_W'(r_ay) * SQ_W'(r_ay);
                r_prod <= PROD_W'(r_width) * PROD_W'(r_ay);
            end
            PH_LEN: begin
                r_len2 <= LEN_W'(r_sqx) + LEN_W'(r_sqy);
                r_a2   <= A2_W'(r_prod) * A2_W'(r_prod);
            end
            PH_INIT: begin
                r_rem  <= $signed(ACC_W'(r_a2)) - w_len_acc;
                r_u    <= -(w_len_acc <<< INIT_U_SHIFT);
                r_v    <= w_len_acc <<< INIT_V_SHIFT;
                r_q    <= '0;
                r_step <= STEP_W'(Q_W - 1);
            end
            PH_ITER: begin
                if (w_take) begin
                    r_rem <= w_cand;
                    r_q   <= r_q | (Q_W'(1) << r_step);
                end
                r_u    <= w_u_acc >>> 1;
                r_v    <= r_v >>> 2;
                r_step <= r_step - STEP_W'(1);
            end
            PH_SAVE: begin
                r_mx   <= r_q;
                r_prod <= PROD_W'(r_width) * PROD_W'(r_ax);
            end
            default: begin
            end
        endcase
    end

    // normal is (ty, -tx) turned to length width/2
    assign w_mag_x  = $signed(SUM_W'(r_mx));
    assign w_mag_y  = $signed(SUM_W'(r_q));
    assign w_nx     = r_deg ? '0 : (r_ty[TAN_W-1] ? -w_mag_x : w_mag_x);
    assign w_ny     = r_deg ? '0 :
                      ((!r_tx[TAN_W-1] && r_tx != '0) ? -w_mag_y : w_mag_y);
    assign w_cx_ext = SUM_W'(r_cx);
    assign w_cy_ext = SUM_W'(r_cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.phase == PH_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.phase == PH_OUT) begin
            r_out_lx    <= sat_coord(w_cx_ext + w_nx);
            r_out_ly    <= sat_coord(w_cy_ext + w_ny);
            r_out_rx    <= sat_coord(w_cx_ext - w_nx);
            r_out_ry    <= sat_coord(w_cy_ext - w_ny);
            r_out_deg   <= r_deg;
            r_out_final <= r_last;
        end
    end

    assign o_status.iter_last = (r_step == '0);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_left_x     = r_out_lx;
    assign o_left_y     = r_out_ly;
    assign o_right_x    = r_out_rx;
    assign o_right_y    = r_out_ry;
    assign o_degenerate = r_out_deg;
    assign o_final      = r_out_final;

endmodule

[hw/rtl/polyline_offset_stroke.sv]
// polyline offset stroke: turns a path of centre points into left and right
// outline points at half the stroke width either side of the path.
// channels: i_pt takes one centre point per request, path_end on the last;
// o_res gives two offset points per centre point, one point behind the input,
// and the request for the last point brings out two results, final_result on
// the second; i_cfg writes stroke_width (Q16.0 full width, coordinate
// units), always ready. a result runs load, abs, square, length, init and
// search for x, save, length, init and search for y, then out; a point that
// only starts a path gives no result and frees the input after load. no
// point is taken until the unit is back in idle. the shared normalisation
// unit searches each normal component one bit a cycle, 16 steps, x then y.
// a lone path_end point gives a zero normal with degenerate set.
// reset: stroke_width returns to 16, the path state is cleared and no result
// is pending.
// stall: one output register holds a finished result; the next point is taken
// while it waits, and the unit holds before its next result until it drains.
module polyline_offset_stroke import pos_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pos_in_if.sink       i_pt,
    pos_cfg_if.sink      i_cfg,
    pos_out_if.source    o_res
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    assign i_pt.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    pos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .i_path_end (i_pt.path_end),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    pos_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_point_x    (i_pt.point_x),
        .i_point_y    (i_pt.point_y),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_width  (i_cfg.stroke_width),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_left_x     (o_res.left_x),
        .o_left_y     (o_res.left_y),
        .o_right_x    (o_res.right_x),
        .o_right_y    (o_res.right_y),
        .o_degenerate (o_res.degenerate),
        .o_final      (o_res.final_result)
    );

endmodule

[hw/rtl/pos_checker.sv]
module pos_checker import pos_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic signed [COORD_W-1:0] i_left_x,
    input logic signed [COORD_W-1:0] i_left_y,
    input logic signed [COORD_W-1:0] i_right_x,
    input logic signed [COORD_W-1:0] i_right_y,
    input logic                      i_degenerate,
    input logic                      i_final
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_left_x) && $stable(i_left_y)
            && $stable(i_right_x) && $stable(i_right_y)
            && $stable(i_degenerate) && $stable(i_final))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

    // one point in flight: busy straight after a request is taken
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second point taken while busy");

    // zero normal leaves both outline points on the centre
    a_degenerate_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degenerate |-> i_left_x == i_right_x && i_left_y == i_right_y)
        else $error("degenerate result with nonzero offset");

endmodule

bind polyline_offset_stroke pos_checker u_pos_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pt.valid),
    .i_in_ready   (i_pt.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_left_x     (o_res.left_x),
    .i_left_y     (o_res.left_y),
    .i_right_x    (o_res.right_x),
    .i_right_y    (o_res.right_y),
    .i_degenerate (o_res.degenerate),
    .i_final      (o_res.final_result)
);

[tb/sv/tb_polyline_offset_stroke.sv]
module tb_polyline_offset_stroke;
    import pos_pkg::*;

    localparam int     RANDOM_ITEMS = 1720;
    localparam int     N_PHASES     = 8;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     SETTLE       = 60;
    localparam int     IDLE_LIMIT   = 3000;
    localparam longint TAN_CAP      = longint'(1) << 18;

    typedef struct {
        logic signed [COORD_W-1:0] left_x;
        logic signed [COORD_W-1:0] left_y;
        logic signed [COORD_W-1:0] right_x;
        logic signed [COORD_W-1:0] right_y;
        logic                      degenerate;
        logic                      final_result;
    } t_outline;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
        int                        n_typed;
        t_outline                  r0;
        t_outline                  r1;
    } t_stim_row;

    typedef enum int {
        MODE_WALK,
        MODE_STILL,
        MODE_JUMP,
        MODE_EDGE,
        MODE_ZIGZAG
    } t_pick_mode;

    localparam t_outline NO_RES = '{default: 0};

    logic clk;
    logic rst_n;

    pos_in_if  pt_if ();
    pos_cfg_if cfg_if ();
    pos_out_if res_if ();

    polyline_offset_stroke dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pt    (pt_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // predictor state
    logic [WIDTH_W-1:0]        stroke_w;
    logic signed [COORD_W-1:0] path_hx;
    logic signed [COORD_W-1:0] path_hy;
    logic signed [DIFF_W-1:0]  path_pdx;
    logic signed [DIFF_W-1:0]  path_pdy;
    t_seen                     path_seen;

    t_outline outlines_due[$];

    // typed expectations for directed rows, zero count means use the predictor
    int       typed_n;
    t_outline typed0;
    t_outline typed1;

    bit gaps_on;
    bit hold_req;

    int errors;
    int n_points;
    int n_results;
    int n_degenerate;
    int n_final;
    int n_widths;

    initial clk = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [COORD_W-1:0] sat_coord(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (COORD_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[COORD_W-1:0];
    endfunction

    function automatic t_outline mk_outline(input longint lx, input longint ly,
                                            input longint rx, input longint ry,
                                            input logic deg, input logic fin);
        t_outline o;
        o.left_x       = lx[COORD_W-1:0];
        o.left_y       = ly[COORD_W-1:0];
        o.right_x      = rx[COORD_W-1:0];
        o.right_y      = ry[COORD_W-1:0];
        o.degenerate   = deg;
        o.final_result = fin;
        return o;
    endfunction

    // largest q with (2q-1)^2 * len2 <= (w*c)^2, i.e. w*c/(2|t|) rounded half up
    function automatic longint normal_len(input longint w, input longint c, input longint len2);
        logic [127:0] a2;
        logic [127:0] b2;
        longint       a;
        longint       b;
        longint       q;
        longint       cand;
        int           i;
        a  = w * c;
        a2 = 128'(a) * 128'(a);
        q  = 0;
        for (i = Q_W - 1; i >= 0; i--) begin
            cand = q | (longint'(1) << i);
            b    = 2 * cand - 1;
            b2   = 128'(b * b) * 128'(len2);
            if (b2 <= a2) q = cand;
        end
        return q;
    endfunction

    function automatic t_outline offset_pair(input longint cx, input longint cy,
                                             input longint tx, input longint ty,
                                             input logic last);
        longint ax;
        longint ay;
        longint nx;
        longint ny;
        longint mx;
        longint my;
        longint len2;
        logic   deg;
        ax  = (tx < 0) ? -tx : tx;
        ay  = (ty < 0) ? -ty : ty;
        nx  = 0;
        ny  = 0;
        deg = (ax == 0) && (ay == 0);
        if (!deg) begin
            while (ax >= TAN_CAP || ay >= TAN_CAP) begin
                ax = ax >>> 1;
                ay = ay >>> 1;
            end
            len2 = ax * ax + ay * ay;
            mx   = normal_len(longint'(stroke_w), ay, len2);
            my   = normal_len(longint'(stroke_w), ax, len2);
            nx   = (ty < 0) ? -mx : mx;
            ny   = (tx > 0) ? -my : my;
        end
        return mk_outline(sat_coord(cx + nx), sat_coord(cy + ny),
                          sat_coord(cx - nx), sat_coord(cy - ny), deg, last);
    endfunction

    function automatic void clear_path();
        path_hx   = '0;
        path_hy   = '0;
        path_pdx  = '0;
        path_pdy  = '0;
        path_seen = SEEN_NONE;
    endfunction

    // advances the path state by one centre point, returns the number of results
    function automatic int walk_point(input longint px, input longint py, input logic last,
                                      output t_outline r0, output t_outline r1);
        longint dx;
        longint dy;
        r0 = NO_RES;
        r1 = NO_RES;
        if (path_seen == SEEN_NONE) begin
            if (last) begin
                r0 = offset_pair(px, py, 0, 0, 1'b1);
                clear_path();
                return 1;
            end
            path_hx   = px[COORD_W-1:0];
            path_hy   = py[COORD_W-1:0];
            path_seen = SEEN_ONE;
            return 0;
        end
        dx = px - path_hx;
        dy = py - path_hy;
        if (path_seen == SEEN_ONE)
            r0 = offset_pair(path_hx, path_hy, 2 * dx, 2 * dy, 1'b0);
        else
            r0 = offset_pair(path_hx, path_hy, path_pdx + dx, path_pdy + dy, 1'b0);
        if (last) begin
            r1 = offset_pair(px, py, 2 * dx, 2 * dy, 1'b1);
            clear_path();
            return 2;
        end
        path_pdx  = dx[DIFF_W-1:0];
        path_pdy  = dy[DIFF_W-1:0];
        path_hx   = px[COORD_W-1:0];
        path_hy   = py[COORD_W-1:0];
        path_seen = SEEN_PRIOR;
        return 1;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin : scoreboard
        t_outline due [2];
        t_outline want;
        int       n;
        if (rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                stroke_w = cfg_if.stroke_width;
                n_widths++;
            end
            if (pt_if.valid && pt_if.ready) begin
                n = walk_point(pt_if.point_x, pt_if.point_y, pt_if.path_end, due[0], due[1]);
                if (typed_n != 0) begin
                    n      = typed_n;
                    due[0] = typed0;
                    due[1] = typed1;
                end
                for (int k = 0; k < n; k++) outlines_due.push_back(due[k]);
                n_points++;
            end
            if (res_if.valid && res_if.ready) begin
                n_results++;
                if (res_if.degenerate) n_degenerate++;
                if (res_if.final_result) n_final++;
                if (outlines_due.size() == 0) begin
                    $error("offset pair arrived with nothing expected");
                    errors++;
                end else begin
                    want = outlines_due.pop_front();
                    check_field("left_x", want.left_x, res_if.left_x);
                    check_field("left_y", want.left_y, res_if.left_y);
                    check_field("right_x", want.right_x, res_if.right_x);
                    check_field("right_y", want.right_y, res_if.right_y);
                    check_field("degenerate", want.degenerate, res_if.degenerate);
                    check_field("final_result", want.final_result, res_if.final_result);
                end
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // output side: random stalls per result, one long hold-off on request
    initial begin : drain
        int stall;
        res_if.ready = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                res_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else begin
                stall = gaps_on ? $urandom_range(0, 7) : 0;
                if (stall != 0) begin
                    res_if.ready = 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            res_if.ready = 1'b1;
            do @(posedge clk); while (!res_if.valid);
        end
    end

    task automatic send_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y, input logic last);
        int gap;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            pt_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pt_if.point_x  = x;
        pt_if.point_y  = y;
        pt_if.path_end = last;
        pt_if.valid    = 1'b1;
        do @(posedge clk); while (!pt_if.ready);
        @(negedge clk);
    endtask

    // waits for every pending result, then for the unit to go quiet
    task automatic settle();
        pt_if.valid = 1'b0;
        while (outlines_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_width(input logic [WIDTH_W-1:0] w);
        cfg_if.stroke_width = w;
        cfg_if.valid        = 1'b1;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic logic signed [COORD_W-1:0] next_coord(
        input t_pick_mode                mode,
        input int                        idx,
        input logic signed [COORD_W-1:0] prev,
        input logic signed [COORD_W-1:0] prev2
    );
        logic signed [COORD_W-1:0] v;
        v = COORD_W'($urandom);
        case (mode)
            MODE_WALK: begin
                if (idx != 0) v = sat_coord(prev + int'($urandom_range(0, 64)) - 32);
            end
            MODE_STILL: begin
                if (idx != 0) v = sat_coord(prev + int'($urandom_range(0, 2)) - 1);
            end
            MODE_EDGE: begin
                case ($urandom_range(0, 3))
                    0: v = COORD_W'(-32768);
                    1: v = COORD_W'(32767);
                    2: v = '0;
                    default: v = COORD_W'($urandom);
                endcase
            end
            MODE_ZIGZAG: begin
                // back and forth between two points cancels the tangent mid-path
                if (idx >= 2) v = prev2;
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_paths(input int n_items);
        int                        sent;
        int                        len;
        t_pick_mode                mode;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] ppx;
        logic signed [COORD_W-1:0] ppy;
        sent = 0;
        while (sent < n_items) begin
            len  = ($urandom_range(0, 11) == 0) ? 1 : $urandom_range(2, 9);
            mode = t_pick_mode'($urandom_range(0, 4));
            px   = '0;
            py   = '0;
            ppx  = '0;
            ppy  = '0;
            for (int i = 0; i < len; i++) begin
                x   = next_coord(mode, i, px, ppx);
                y   = next_coord(mode, i, py, ppy);
                ppx = px;
                ppy = py;
                px  = x;
                py  = y;
                send_point(x, y, i == len - 1);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        t_stim_row          plan [21];
        logic [WIDTH_W-1:0] widths [N_PHASES];
        int                 p;

        rst_n               = 1'b0;
        pt_if.valid         = 1'b0;
        pt_if.point_x       = '0;
        pt_if.point_y       = '0;
        pt_if.path_end      = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.stroke_width = '0;
        gaps_on             = 1'b1;
        hold_req            = 1'b0;
        typed_n             = 0;
        typed0              = NO_RES;
        typed1              = NO_RES;
        errors              = 0;
        n_points            = 0;
        n_results           = 0;
        n_degenerate        = 0;
        n_final             = 0;
        n_widths            = 0;
        stroke_w            = WIDTH_RESET;
        clear_path();

        // directed rows run at the reset width of 16
        plan = '{
            '{0, 0, 1, 1, mk_outline(0, 0, 0, 0, 1, 1), NO_RES},
            '{32767, -32768, 1, 1, mk_outline(32767, -32768, 32767, -32768, 1, 1), NO_RES},
            '{0, 0, 0, 0, NO_RES, NO_RES},
            '{16, 0, 1, 2, mk_outline(0, -8, 0, 8, 0, 0), mk_outline(16, -8, 16, 8, 0, 1)},
            '{5, 5, 0, 0, NO_RES, NO_RES},
            '{5, 5, 1, 2, mk_outline(5, 5, 5, 5, 1, 0), mk_outline(5, 5, 5, 5, 1, 1)},
            '{32767, 0, 0, 0, NO_RES, NO_RES},
            '{32767, 32767, 1, 2, mk_outline(32767, 0, 32759, 0, 0, 0),
              mk_outline(32767, 32767, 32759, 32767, 0, 1)},
            '{-32768, 0, 0, 0, NO_RES, NO_RES},
            '{-32768, -32767, 1, 2, mk_outline(-32768, 0, -32760, 0, 0, 0),
              mk_outline(-32768, -32767, -32760, -32767, 0, 1)},
            '{-32768, -32768, 0, 0, NO_RES, NO_RES},
            '{32767, 32767, 0, 0, NO_RES, NO_RES},
            '{-32768, -32768, 0, 0, NO_RES, NO_RES},
            '{0, 0, 0, 0, NO_RES, NO_RES},
            '{0, 0, 0, 0, NO_RES, NO_RES},
            '{-1, -1, 1, 0, NO_RES, NO_RES},
            '{100, 0, 0, 0, NO_RES, NO_RES},
            '{100, 100, 0, 0, NO_RES, NO_RES},
            '{0, 100, 0, 0, NO_RES, NO_RES},
            '{-3, 7, 0, 0, NO_RES, NO_RES},
            '{0, 0, 1, 0, NO_RES, NO_RES}
        };
        widths = '{16'hFFFF, 16'd0, 16'd1, 16'd48, 16'($urandom), 16'd320,
                   16'($urandom), 16'hFFFE};

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i]) begin
            typed_n = plan[i].n_typed;
            typed0  = plan[i].r0;
            typed1  = plan[i].r1;
            send_point(plan[i].x, plan[i].y, plan[i].last);
        end
        typed_n = 0;

        for (p = 0; p < N_PHASES; p++) begin
            settle();
            write_width(widths[p]);
            // one phase runs back to back against a long output hold-off
            gaps_on = (p != 3);
            if (p == 3) hold_req = 1'b1;
            send_paths(RANDOM_ITEMS / N_PHASES);
        end
        settle();

        $display("stroke outline: %0d centre points in, %0d offset pairs out,",
                 n_points, n_results);
        $display("  %0d degenerate, %0d path ends, %0d width settings incl. zero and full scale",
                 n_degenerate, n_final, n_widths);
        $display("  random stalls on both sides and one long output hold-off");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/pos_pkg.sv
hw/rtl/pos_in_if.sv
hw/rtl/pos_out_if.sv
hw/rtl/pos_cfg_if.sv
hw/rtl/pos_ctrl.sv
hw/rtl/pos_dpath.sv
hw/rtl/polyline_offset_stroke.sv
hw/rtl/pos_checker.sv
tb/sv/tb_polyline_offset_stroke.sv
